// File: rtl/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    // Default parameter values for the top level.
    localparam int COORD_BITS_DEF      = 12;
    localparam int SCALE_FRAC_BITS_DEF = 14;

    // Fixed field widths of the stream and configuration ports.
    localparam int IN_COORD_W = 12;
    localparam int SIZE_W     = 12;
    localparam int CFG_W      = 12;
    localparam int REJ_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int RESULT_W   = 16;

    // Per-axis correction toward the aimed corner.
    localparam int CORR = 10;

    // Lowest offset that passes the range check, Q12.4 (-200.0).
    localparam logic signed [RESULT_W-1:0] OFFSET_MIN = -16'sd3200;

    // Configuration register indexes.
    localparam logic [1:0] REG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN_DISTANCE   = 2'd2;
    localparam logic [1:0] REG_MAX_REJECTIONS = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] DISPLAY_WIDTH_RST  = 12'd1024;
    localparam logic [CFG_W-1:0] DISPLAY_HEIGHT_RST = 12'd768;
    localparam logic [CFG_W-1:0] MIN_DISTANCE_RST   = 12'd100;
    localparam logic [REJ_W-1:0] MAX_REJECTIONS_RST = 4'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POINT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABORTED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE_GOOD = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE_BAD  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd6;

    // Calibration phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_UL   = 2'd1;
    localparam logic [1:0] PH_UR   = 2'd2;
    localparam logic [1:0] PH_LL   = 2'd3;

endpackage

`default_nettype wire

// File: rtl/tpc_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module tpc_divider #(
    parameter int DIVIDEND_BITS = 25,
    parameter int DIVISOR_BITS  = 14
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // Shift the next dividend bit into the remainder and try a subtract.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = trial >= {1'b0, dvs_reg};
    end

    // Sequencing of the iterations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/three_point_touch_calibrator.sv
`timescale 1ns / 1ps
`default_nettype none

// Start, upper-left and idle presses go from idle straight to the output step; an upper-right press
// adds a distance test (SQX, SQY, SQM, CMP); a lower-left press adds the distance tests and,
// per axis, a serial divider run plus the shared multiplier steps (AXIS, DIV, OFFM, OFFS).
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous) clears phase, corners, reject count and loads defaults.
module three_point_touch_calibrator #(
    parameter int COORD_BITS      = tpc_pkg::COORD_BITS_DEF,
    parameter int SCALE_FRAC_BITS = tpc_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // touch_x[11:0], touch_y[23:12]
    input  wire logic [0:0]  s_tuser,   // kind[0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // x_scale[15:0], x_offset[31:16], y_scale[47:32],
                                        // y_offset[63:48], rejections_so_far[67:64], zero
    output logic [2:0]       m_tuser    // status[2:0]
);

    localparam int CW       = COORD_BITS + 2;
    localparam int IN_BITS  = (COORD_BITS < tpc_pkg::IN_COORD_W) ? COORD_BITS
                                                                   : tpc_pkg::IN_COORD_W;
    localparam int MW       = (CW + 2 > 17) ? CW + 2 : 17;
    localparam int PW       = 2 * MW;
    localparam int DW       = tpc_pkg::SIZE_W + SCALE_FRAC_BITS - 1;
    localparam int OFF_SH   = SCALE_FRAC_BITS - 4;
    localparam int unsigned SCALE_LIMIT = 32'd2 << SCALE_FRAC_BITS;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SQM  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_AXIS = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_OFFM = 4'd7;
    localparam logic [3:0] S_OFFS = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    // Point pairs of the distance test.
    localparam logic [1:0] PAIR_UL_UR = 2'd0;
    localparam logic [1:0] PAIR_UR_LL = 2'd1;
    localparam logic [1:0] PAIR_UL_LL = 2'd2;

    localparam logic signed [CW-1:0] CORR_C = CW'(tpc_pkg::CORR);

    // Control registers.
    logic [3:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  rc_reg, rc_next;
    logic [1:0]  pair_reg, pair_next;
    logic        axis_reg, axis_next;
    logic        good_reg, good_next;
    logic [2:0]  status_reg, status_next;
    logic        m_valid_reg, m_valid_next;

    // Configuration registers.
    logic [11:0] width_reg, height_reg, min_dist_reg;
    logic [3:0]  max_rej_reg;

    // Corner registers.
    logic signed [CW-1:0] ul_x_reg, ul_x_next, ul_y_reg, ul_y_next;
    logic signed [CW-1:0] ur_x_reg, ur_x_next, ur_y_reg, ur_y_next;
    logic signed [CW-1:0] ll_x_reg, ll_x_next, ll_y_reg, ll_y_next;

    // Datapath registers.
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic [15:0] scale_cur_reg, scale_cur_next;
    logic [15:0] xs_reg, xs_next, xo_reg, xo_next;
    logic [15:0] ys_reg, ys_next, yo_reg, yo_next;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    // Combinational helpers.
    logic                 in_xfer;
    logic                 out_load;
    logic signed [CW-1:0] tx, ty;
    logic signed [CW-1:0] pa_x, pa_y, pb_x, pb_y;
    logic signed [CW:0]   dx, dy;
    logic signed [CW:0]   span, sum;
    logic [CW:0]          asum;
    logic                 span_pos, sum_pos;
    logic [11:0]          size;
    logic signed [MW-1:0] mul_a, mul_b;
    logic [3:0]           rc_inc;
    logic                 abort;
    logic                 close;
    logic [PW-1:0]        mag_full;
    logic [15:0]          mag;
    logic signed [16:0]   off17;
    logic [15:0]          off16;
    logic                 axis_ok;
    logic [15:0]          sc_sat;
    logic                 div_start, div_done;
    logic [DW-1:0]        div_quo;

    tpc_divider #(
        .DIVIDEND_BITS(DW),
        .DIVISOR_BITS (CW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend({size, {(SCALE_FRAC_BITS - 1){1'b0}}}),
        .divisor (span[CW-1:0]),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_FIN) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Raw coordinates, masked to the coordinate width.
    always_comb begin
        tx = $signed({{(CW - IN_BITS){1'b0}}, s_tdata[IN_BITS-1:0]});
        ty = $signed({{(CW - IN_BITS){1'b0}}, s_tdata[tpc_pkg::IN_COORD_W +: IN_BITS]});
    end

    // Operands of the current distance pair.
    always_comb begin
        case (pair_reg)
            PAIR_UL_UR: begin
                pa_x = ul_x_reg; pa_y = ul_y_reg; pb_x = ur_x_reg; pb_y = ur_y_reg;
            end
            PAIR_UR_LL: begin
                pa_x = ur_x_reg; pa_y = ur_y_reg; pb_x = ll_x_reg; pb_y = ll_y_reg;
            end
            default: begin
                pa_x = ul_x_reg; pa_y = ul_y_reg; pb_x = ll_x_reg; pb_y = ll_y_reg;
            end
        endcase
        dx = (CW + 1)'(pa_x) - (CW + 1)'(pb_x);
        dy = (CW + 1)'(pa_y) - (CW + 1)'(pb_y);
    end

    // Span, coordinate sum and display size of the current axis.
    always_comb begin
        if (axis_reg) begin
            span = (CW + 1)'(ll_y_reg) - (CW + 1)'(ul_y_reg);
            sum  = (CW + 1)'(ul_y_reg) + (CW + 1)'(ur_y_reg);
            size = height_reg;
        end else begin
            span = (CW + 1)'(ur_x_reg) - (CW + 1)'(ul_x_reg);
            sum  = (CW + 1)'(ul_x_reg) + (CW + 1)'(ll_x_reg);
            size = width_reg;
        end
        span_pos = !span[CW] && (span != '0);
        sum_pos  = !sum[CW] && (sum != '0);
        asum     = sum[CW] ? unsigned'(-sum) : unsigned'(sum);
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (state_reg)
            S_SQX: begin
                mul_a = MW'(dx);
                mul_b = MW'(dx);
            end
            S_SQY: begin
                mul_a = MW'(dy);
                mul_b = MW'(dy);
            end
            S_SQM: begin
                mul_a = $signed({{(MW - 12){1'b0}}, min_dist_reg});
                mul_b = $signed({{(MW - 12){1'b0}}, min_dist_reg});
            end
            S_OFFM: begin
                mul_a = $signed({{(MW - 16){1'b0}}, scale_cur_reg});
                mul_b = $signed({{(MW - CW - 1){1'b0}}, asum});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rejection counting, distance compare, scale saturation and offset shaping.
    always_comb begin
        rc_inc   = (rc_reg == 4'd15) ? rc_reg : rc_reg + 4'd1;
        abort    = rc_inc >= max_rej_reg;
        close    = acc_reg < prod_reg;
        sc_sat   = (|div_quo[DW-1:16]) ? 16'hFFFF : div_quo[15:0];
        mag_full = unsigned'(prod_reg) >> OFF_SH;
        mag      = (mag_full > PW'(32768)) ? 16'h8000 : mag_full[15:0];
        if (sum_pos) begin
            off17 = -$signed({1'b0, mag});
        end else if (mag == 16'h8000) begin
            off17 = 17'sd32767;
        end else begin
            off17 = $signed({1'b0, mag});
        end
        off16   = off17[15:0];
        axis_ok = (32'(scale_cur_reg) <= SCALE_LIMIT) && ($signed(off16) <= 16'sd0)
                  && ($signed(off16) >= tpc_pkg::OFFSET_MIN);
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        rc_next        = rc_reg;
        pair_next      = pair_reg;
        axis_next      = axis_reg;
        good_next      = good_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg;
        ul_x_next      = ul_x_reg;
        ul_y_next      = ul_y_reg;
        ur_x_next      = ur_x_reg;
        ur_y_next      = ur_y_reg;
        ll_x_next      = ll_x_reg;
        ll_y_next      = ll_y_reg;
        acc_next       = acc_reg;
        scale_cur_next = scale_cur_reg;
        xs_next        = xs_reg;
        xo_next        = xo_reg;
        ys_next        = ys_reg;
        yo_next        = yo_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        div_start      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_FIN;
                    if (s_tuser[0]) begin
                        rc_next     = '0;
                        phase_next  = tpc_pkg::PH_UL;
                        status_next = tpc_pkg::ST_STARTED;
                    end else begin
                        case (phase_reg)
                            tpc_pkg::PH_UL: begin
                                ul_x_next   = tx - CORR_C;
                                ul_y_next   = ty - CORR_C;
                                phase_next  = tpc_pkg::PH_UR;
                                status_next = tpc_pkg::ST_POINT;
                            end
                            tpc_pkg::PH_UR: begin
                                ur_x_next  = tx + CORR_C;
                                ur_y_next  = ty - CORR_C;
                                pair_next  = PAIR_UL_UR;
                                state_next = S_SQX;
                            end
                            tpc_pkg::PH_LL: begin
                                ll_x_next  = tx - CORR_C;
                                ll_y_next  = ty + CORR_C;
                                pair_next  = PAIR_UR_LL;
                                state_next = S_SQX;
                            end
                            default: begin
                                status_next = tpc_pkg::ST_IGNORED;
                            end
                        endcase
                    end
                end
            end
            S_SQX: begin
                state_next = S_SQY;
            end
            S_SQY: begin
                acc_next   = prod_reg;
                state_next = S_SQM;
            end
            S_SQM: begin
                acc_next   = acc_reg + prod_reg;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (close) begin
                    rc_next    = rc_inc;
                    state_next = S_FIN;
                    if (abort) begin
                        phase_next  = tpc_pkg::PH_IDLE;
                        status_next = tpc_pkg::ST_ABORTED;
                    end else begin
                        status_next = tpc_pkg::ST_REJECTED;
                    end
                end else begin
                    case (pair_reg)
                        PAIR_UL_UR: begin
                            phase_next  = tpc_pkg::PH_LL;
                            status_next = tpc_pkg::ST_POINT;
                            state_next  = S_FIN;
                        end
                        PAIR_UR_LL: begin
                            pair_next  = PAIR_UL_LL;
                            state_next = S_SQX;
                        end
                        default: begin
                            phase_next = tpc_pkg::PH_IDLE;
                            axis_next  = 1'b0;
                            good_next  = 1'b1;
                            state_next = S_AXIS;
                        end
                    endcase
                end
            end
            S_AXIS: begin
                if (span_pos) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    // A zero or negative span zeroes the axis and fails the run.
                    good_next = 1'b0;
                    if (axis_reg) begin
                        ys_next     = '0;
                        yo_next     = '0;
                        status_next = tpc_pkg::ST_DONE_BAD;
                        state_next  = S_FIN;
                    end else begin
                        xs_next   = '0;
                        xo_next   = '0;
                        axis_next = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    scale_cur_next = sc_sat;
                    state_next     = S_OFFM;
                end
            end
            S_OFFM: begin
                state_next = S_OFFS;
            end
            S_OFFS: begin
                good_next = good_reg && axis_ok;
                if (axis_reg) begin
                    ys_next     = scale_cur_reg;
                    yo_next     = off16;
                    status_next = (good_reg && axis_ok) ? tpc_pkg::ST_DONE_GOOD
                                                        : tpc_pkg::ST_DONE_BAD;
                    state_next  = S_FIN;
                end else begin
                    xs_next    = scale_cur_reg;
                    xo_next    = off16;
                    axis_next  = 1'b1;
                    state_next = S_AXIS;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_tuser_next = status_reg;
                    if (status_reg inside {tpc_pkg::ST_DONE_GOOD, tpc_pkg::ST_DONE_BAD}) begin
                        m_tdata_next = {4'd0, rc_reg, yo_reg, ys_reg, xo_reg, xs_reg};
                    end else begin
                        m_tdata_next = {4'd0, rc_reg, 64'd0};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= tpc_pkg::PH_IDLE;
            rc_reg       <= '0;
            pair_reg     <= PAIR_UL_UR;
            axis_reg     <= 1'b0;
            good_reg     <= 1'b0;
            status_reg   <= tpc_pkg::ST_STARTED;
            m_valid_reg  <= 1'b0;
            ul_x_reg     <= '0;
            ul_y_reg     <= '0;
            ur_x_reg     <= '0;
            ur_y_reg     <= '0;
            ll_x_reg     <= '0;
            ll_y_reg     <= '0;
            width_reg    <= tpc_pkg::DISPLAY_WIDTH_RST;
            height_reg   <= tpc_pkg::DISPLAY_HEIGHT_RST;
            min_dist_reg <= tpc_pkg::MIN_DISTANCE_RST;
            max_rej_reg  <= tpc_pkg::MAX_REJECTIONS_RST;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            rc_reg      <= rc_next;
            pair_reg    <= pair_next;
            axis_reg    <= axis_next;
            good_reg    <= good_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            ul_x_reg    <= ul_x_next;
            ul_y_reg    <= ul_y_next;
            ur_x_reg    <= ur_x_next;
            ur_y_reg    <= ur_y_next;
            ll_x_reg    <= ll_x_next;
            ll_y_reg    <= ll_y_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    tpc_pkg::REG_DISPLAY_WIDTH:  width_reg    <= cfg_wdata;
                    tpc_pkg::REG_DISPLAY_HEIGHT: height_reg   <= cfg_wdata;
                    tpc_pkg::REG_MIN_DISTANCE:   min_dist_reg <= cfg_wdata;
                    tpc_pkg::REG_MAX_REJECTIONS: max_rej_reg  <= cfg_wdata[3:0];
                    default:                     width_reg    <= width_reg;
                endcase
            end
        end
    end

    // Datapath registers; the multiplier output is registered every cycle.
    always_ff @(posedge aclk) begin
        prod_reg      <= PW'(mul_a) * PW'(mul_b);
        acc_reg       <= acc_next;
        scale_cur_reg <= scale_cur_next;
        xs_reg        <= xs_next;
        xo_reg        <= xo_next;
        ys_reg        <= ys_next;
        yo_reg        <= yo_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // The divider only finishes while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    // A finished or aborted run always leaves the phase idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (status_reg == tpc_pkg::ST_ABORTED ||
                     status_reg == tpc_pkg::ST_DONE_GOOD ||
                     status_reg == tpc_pkg::ST_DONE_BAD)
        |-> (phase_reg == tpc_pkg::PH_IDLE))
        else $error("run ended with phase not idle");

    // An abort is reported only once the rejection limit is reached.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (status_reg == tpc_pkg::ST_ABORTED) |-> (rc_reg >= max_rej_reg))
        else $error("abort below the rejection limit");

    // Scale and offset fields are zero unless the run completed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_tuser_reg != tpc_pkg::ST_DONE_GOOD) &&
        (m_tuser_reg != tpc_pkg::ST_DONE_BAD) |-> (m_tdata_reg[63:0] == 64'd0))
        else $error("calibration values on a non-final result");

endmodule

`default_nettype wire
